/* rtl/fsrc_pkg.sv */
package fsrc_pkg;

    localparam int unsigned ADC_W  = 12;
    localparam int unsigned CH_W   = 4;
    localparam int unsigned PCT_W  = 7;
    localparam logic [ADC_W-1:0] ADC_TOP = 12'd4095;

    typedef enum logic [1:0] {
        FUNC_MEASURE = 2'd0,
        FUNC_CAL     = 2'd1,
        FUNC_LOAD    = 2'd2,
        FUNC_NONE    = 2'd3
    } func_t;

    localparam logic CFG_DB_FLOOR    = 1'b0;
    localparam logic CFG_RISE_MARGIN = 1'b1;

    typedef struct packed {
        logic [1:0]       func;
        logic [CH_W-1:0]  channel;
        logic [ADC_W-1:0] sample_a;
        logic [ADC_W-1:0] sample_b;
        logic [ADC_W-1:0] sample_c;
        logic [ADC_W-1:0] sample_d;
        logic [ADC_W-1:0] sample_e;
        logic [ADC_W-1:0] load_idle;
        logic [ADC_W-1:0] load_deadband;
    } in_item_t;

    typedef struct packed {
        logic [CH_W-1:0]  out_channel;
        logic [ADC_W-1:0] smoothed_level;
        logic [PCT_W-1:0] press_percent;
        logic             cal_done;
        logic [ADC_W-1:0] idle_level;
        logic [ADC_W-1:0] deadband_level;
        logic             load_rejected;
    } out_item_t;

    // classified command passed from front end to back end
    typedef struct packed {
        logic [1:0]       func;
        logic [CH_W-1:0]  channel;
        logic             in_range;
        logic [ADC_W-1:0] median;
        logic [ADC_W-1:0] load_idle;
        logic [ADC_W-1:0] load_deadband;
    } cmd_t;

    function automatic logic [ADC_W-1:0] med3(input logic [ADC_W-1:0] a,
                                              input logic [ADC_W-1:0] b,
                                              input logic [ADC_W-1:0] c);
        logic [ADC_W-1:0] lo;
        logic [ADC_W-1:0] hi;
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
        if (c <= lo)
            return lo;
        else if (c >= hi)
            return hi;
        else
            return c;
    endfunction

endpackage

/* rtl/fsrc_front.sv */
module fsrc_front #(
    parameter int unsigned CHANNELS = 9
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  fsrc_pkg::in_item_t in_item,
    output logic              cmd_valid,
    input  logic              cmd_ready,
    output fsrc_pkg::cmd_t    cmd
);
    import fsrc_pkg::*;

    // stage 1: sorting network pieces; stage 2: median select
    logic [ADC_W-1:0] lo_ab_reg, hi_ab_reg, lo_cd_reg, hi_cd_reg, e_reg;
    logic [ADC_W-1:0] lo_ab_next, hi_ab_next, lo_cd_next, hi_cd_next;
    in_item_t         s1_reg;
    logic             s1_valid_reg;
    cmd_t             cmd_reg;
    logic             cmd_valid_reg;
    logic [ADC_W-1:0] m_lo, m_hi, med;
    logic             s2_free;

    assign s2_free  = !cmd_valid_reg || cmd_ready;
    assign in_ready = !s1_valid_reg || s2_free;

    always_comb
    begin
        lo_ab_next = (in_item.sample_a < in_item.sample_b) ? in_item.sample_a : in_item.sample_b;
        hi_ab_next = (in_item.sample_a < in_item.sample_b) ? in_item.sample_b : in_item.sample_a;
        lo_cd_next = (in_item.sample_c < in_item.sample_d) ? in_item.sample_c : in_item.sample_d;
        hi_cd_next = (in_item.sample_c < in_item.sample_d) ? in_item.sample_d : in_item.sample_c;
    end

    // drop the lowest of the two pair minima and the highest of the two pair maxima,
    // then the median of five is the median of the remaining three
    always_comb
    begin
        m_lo = (lo_ab_reg > lo_cd_reg) ? lo_ab_reg : lo_cd_reg;
        m_hi = (hi_ab_reg < hi_cd_reg) ? hi_ab_reg : hi_cd_reg;
        med  = med3(m_lo, m_hi, e_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            cmd_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
                s1_valid_reg <= in_valid;
            if (s2_free)
                cmd_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            s1_reg    <= in_item;
            lo_ab_reg <= lo_ab_next;
            hi_ab_reg <= hi_ab_next;
            lo_cd_reg <= lo_cd_next;
            hi_cd_reg <= hi_cd_next;
            e_reg     <= in_item.sample_e;
        end
        if (s2_free && s1_valid_reg)
        begin
            cmd_reg.func          <= s1_reg.func;
            cmd_reg.channel       <= s1_reg.channel;
            cmd_reg.in_range      <= ({28'd0, s1_reg.channel} < CHANNELS);
            cmd_reg.median        <= med;
            cmd_reg.load_idle     <= s1_reg.load_idle;
            cmd_reg.load_deadband <= s1_reg.load_deadband;
        end
    end

    assign cmd_valid = cmd_valid_reg;
    assign cmd       = cmd_reg;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && !cmd_ready |=> cmd_valid && $stable(cmd))
        else $error("front output changed while stalled");
    a_med_bound: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg |-> (med >= m_lo || med >= e_reg))
        else $error("median below both candidates");
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd.in_range |-> ({28'd0, cmd.channel} < CHANNELS))
        else $error("range flag wrong");

endmodule

/* rtl/fsrc_queue.sv */
module fsrc_queue #(
    parameter int unsigned WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_valid,
    output logic             wr_ready,
    input  logic [WIDTH-1:0] wr_data,
    output logic             rd_valid,
    input  logic             rd_ready,
    output logic [WIDTH-1:0] rd_data
);
    // two-entry queue
    logic [WIDTH-1:0] mem_reg [2];
    logic             wp_reg, rp_reg;
    logic [1:0]       cnt_reg;

    assign wr_ready = (cnt_reg != 2'd2);
    assign rd_valid = (cnt_reg != 2'd0);
    assign rd_data  = mem_reg[rp_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (wr_valid && wr_ready)
                wp_reg <= ~wp_reg;
            if (rd_valid && rd_ready)
                rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, wr_valid && wr_ready} - {1'b0, rd_valid && rd_ready};
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_valid && wr_ready)
            mem_reg[wp_reg] <= wr_data;
    end

    a_cnt: assert property (@(posedge clk) disable iff (!rst_n) cnt_reg != 2'd3)
        else $error("queue count overflow");
    a_ptr: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == 2'd0 || cnt_reg == 2'd2) |-> wp_reg == rp_reg)
        else $error("queue pointers inconsistent");
    a_nofull: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg == 2'd1 |-> wp_reg != rp_reg)
        else $error("queue pointers inconsistent");

endmodule

/* rtl/fsrc_back.sv */
module fsrc_back #(
    parameter int unsigned CHANNELS    = 9,
    parameter int unsigned CAL_SAMPLES = 180,
    parameter int unsigned CAL_SKIP    = 20
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cmd_valid,
    output logic                 cmd_ready,
    input  fsrc_pkg::cmd_t       cmd,
    input  logic [11:0]          db_floor,
    input  logic [11:0]          rise_margin,
    output logic                 out_valid,
    input  logic                 out_ready,
    output fsrc_pkg::out_item_t  out_item
);
    import fsrc_pkg::*;

    localparam int unsigned CAL_N = CAL_SAMPLES - CAL_SKIP;
    localparam logic [7:0]  CAL_SAMPLES_C = 8'(CAL_SAMPLES);
    localparam logic [7:0]  CAL_SKIP_C    = 8'(CAL_SKIP);
    localparam int unsigned NSTEP = 20;  // quotient bits for the percent division
    // total / CAL_N by reciprocal multiply; exact for totals up to CAL_N * 4095
    localparam int unsigned RCP_SH = 28;
    localparam logic [25:0] CAL_RCP =
        26'(((64'd1 << RCP_SH) + 64'(CAL_N) - 64'd1) / 64'(CAL_N));

    typedef enum logic [2:0] {
        S_IDLE, S_READ, S_PCT, S_DIV, S_CALDIV, S_OUT
    } state_t;

    state_t            state_reg;
    cmd_t              c_reg;
    logic [ADC_W-1:0]  smoothed_reg [CHANNELS];
    logic [ADC_W-1:0]  idle_reg     [CHANNELS];
    logic [ADC_W-1:0]  deadband_reg [CHANNELS];
    logic [PCT_W-1:0]  display_reg  [CHANNELS];
    logic [7:0]        cal_count_reg;
    logic [19:0]       cal_total_reg;
    logic [ADC_W-1:0]  cal_lowest_reg, cal_highest_reg, cal_smoothed_reg;
    logic [ADC_W-1:0]  s_reg, den_reg;
    logic [ADC_W-1:0]  sm_cur, idle_cur, db_cur;
    logic [PCT_W-1:0]  disp_cur;
    logic [19:0]       rem_reg, quo_reg, num_reg;
    logic [4:0]        step_reg;
    logic              done_reg, rej_reg;
    out_item_t         out_reg;
    logic              out_valid_reg;
    logic [CH_W-1:0]   ch;

    assign ch       = c_reg.channel;
    assign sm_cur   = smoothed_reg[ch];
    assign idle_cur = idle_reg[ch];
    assign db_cur   = deadband_reg[ch];
    assign disp_cur = display_reg[ch];

    assign cmd_ready = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

    // measure smoothing
    logic [13:0] ms_sum;
    logic [ADC_W-1:0] ms_new;
    // calibration smoothing
    logic [ADC_W-1:0] cp;
    logic [15:0] cs_sum;
    logic [ADC_W-1:0] cs_new;
    logic [7:0]  cnt_inc;
    logic [12:0] base, thr_base;
    logic [13:0] thr;
    logic [12:0] ld_sum;
    always_comb
    begin
        ms_sum  = 14'(sm_cur) * 14'd3 + 14'(c_reg.median) + 14'd2;
        ms_new  = (sm_cur == '0) ? c_reg.median : ms_sum[13:2];
        cp      = (cal_count_reg == 8'd0) ? sm_cur : cal_smoothed_reg;
        cs_sum  = 16'(cp) * 16'd7 + 16'(c_reg.median) + 16'd4;
        cs_new  = (cp == '0) ? c_reg.median : cs_sum[14:3];
        cnt_inc = cal_count_reg + 8'd1;
        base    = 13'(idle_cur) + 13'(db_cur);
        thr_base = base;
        thr     = 14'(thr_base) + 14'(rise_margin);
        ld_sum  = 13'(c_reg.load_idle) + 13'(c_reg.load_deadband);
    end

    // display smoothing with quotient of percent division
    logic [PCT_W-1:0] pct, tgt, dnew, diff;
    logic [PCT_W:0]   up_s, dn_s;
    logic [PCT_W-1:0] step_up, step_dn;
    always_comb
    begin
        pct  = (quo_reg > 20'd100) ? 7'd100 : quo_reg[6:0];
        tgt  = (pct < 7'd3) ? 7'd0 : pct;
        dnew = disp_cur;
        diff = '0;
        up_s = '0;
        dn_s = '0;
        step_up = '0;
        step_dn = '0;
        if (tgt > disp_cur)
        begin
            diff = tgt - disp_cur;
            up_s = {1'b0, diff} + 8'd2;
            // x * 171 >> 9 equals x / 3 for x up to 102
            step_up = 7'((16'(up_s) * 16'd171) >> 9);
            dnew = disp_cur + ((step_up == '0) ? 7'd1 : step_up);
        end
        else if (tgt < disp_cur)
        begin
            diff = disp_cur - tgt;
            dn_s = {1'b0, diff} + 8'd1;
            step_dn = dn_s[7:1];
            dnew = disp_cur - ((step_dn == '0) ? 7'd1 : step_dn);
        end
        if (dnew < 7'd3)
            dnew = '0;
    end

    // restoring divider step for the percent
    logic [20:0] trial;
    logic [19:0] rem_sh;
    always_comb
    begin
        rem_sh = {rem_reg[18:0], num_reg[19]};
        trial  = {1'b0, rem_sh} - 21'(den_reg);
    end

    // calibration average
    logic [45:0]      cal_prod;
    logic [17:0]      cal_q;
    logic [ADC_W-1:0] cal_idle;
    always_comb
    begin
        cal_prod = 46'(num_reg) * 46'(CAL_RCP);
        cal_q    = cal_prod[45:RCP_SH];
        cal_idle = (cal_q > 18'(ADC_TOP)) ? ADC_TOP : cal_q[11:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            out_valid_reg    <= 1'b0;
            cal_count_reg    <= '0;
            cal_total_reg    <= '0;
            cal_lowest_reg   <= ADC_TOP;
            cal_highest_reg  <= '0;
            cal_smoothed_reg <= '0;
            for (int i = 0; i < CHANNELS; i++)
            begin
                smoothed_reg[i] <= '0;
                idle_reg[i]     <= '0;
                deadband_reg[i] <= '0;
                display_reg[i]  <= '0;
            end
        end
        else
        begin
            if (out_valid_reg && out_ready && state_reg != S_OUT)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (cmd_valid)
                    begin
                        c_reg     <= cmd;
                        done_reg  <= 1'b0;
                        rej_reg   <= 1'b0;
                        state_reg <= S_READ;
                    end
                end
                S_READ:
                begin
                    state_reg <= S_OUT;
                    if (c_reg.in_range)
                    begin
                        unique case (func_t'(c_reg.func))
                            FUNC_MEASURE:
                            begin
                                smoothed_reg[ch] <= ms_new;
                                s_reg <= ms_new;
                                state_reg <= S_PCT;
                            end
                            FUNC_CAL:
                            begin
                                cal_smoothed_reg <= cs_new;
                                cal_count_reg    <= cnt_inc;
                                if (cal_count_reg >= CAL_SKIP_C)
                                begin
                                    cal_total_reg <= cal_total_reg + 20'(cs_new);
                                    if (cs_new < cal_lowest_reg)
                                        cal_lowest_reg <= cs_new;
                                    if (cs_new > cal_highest_reg)
                                        cal_highest_reg <= cs_new;
                                end
                                if (cnt_inc >= CAL_SAMPLES_C)
                                begin
                                    num_reg   <= (cal_count_reg >= CAL_SKIP_C)
                                                 ? cal_total_reg + 20'(cs_new)
                                                 : cal_total_reg;
                                    state_reg <= S_CALDIV;
                                end
                            end
                            FUNC_LOAD:
                            begin
                                if (ld_sum >= 13'(ADC_TOP))
                                    rej_reg <= 1'b1;
                                else
                                begin
                                    idle_reg[ch]     <= c_reg.load_idle;
                                    deadband_reg[ch] <= c_reg.load_deadband;
                                    smoothed_reg[ch] <= c_reg.load_idle;
                                    display_reg[ch]  <= '0;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_PCT:
                begin
                    // idle tracking uses the values before this update
                    if (idle_cur > db_cur && 13'(s_reg) + 13'(db_cur) < 13'(idle_cur))
                        idle_reg[ch] <= s_reg;
                    den_reg     <= ADC_TOP - base[11:0];
                    rem_reg     <= '0;
                    quo_reg     <= '0;
                    if (14'(s_reg) <= thr || base >= 13'(ADC_TOP))
                    begin
                        num_reg  <= '0;
                        step_reg <= 5'd0;
                    end
                    else
                    begin
                        // (lvl - base) * 100 as the 20-bit dividend for the 20 step division
                        num_reg  <= 20'((s_reg - base[11:0]) * 19'd100);
                        step_reg <= 5'(NSTEP);
                    end
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    if (step_reg != 5'd0)
                    begin
                        num_reg  <= {num_reg[18:0], 1'b0};
                        step_reg <= step_reg - 5'd1;
                        if (!trial[20])
                        begin
                            rem_reg <= trial[19:0];
                            quo_reg <= {quo_reg[18:0], 1'b1};
                        end
                        else
                        begin
                            rem_reg <= rem_sh;
                            quo_reg <= {quo_reg[18:0], 1'b0};
                        end
                    end
                    else
                    begin
                        display_reg[ch] <= dnew;
                        state_reg <= S_OUT;
                    end
                end
                S_CALDIV:
                begin
                    idle_reg[ch]     <= cal_idle;
                    smoothed_reg[ch] <= cal_idle;
                    deadband_reg[ch] <= ((cal_highest_reg > cal_lowest_reg ?
                                         cal_highest_reg - cal_lowest_reg : 12'd0)
                                         > db_floor)
                                        ? cal_highest_reg - cal_lowest_reg
                                        : db_floor;
                    display_reg[ch]  <= '0;
                    done_reg         <= 1'b1;
                    cal_count_reg    <= '0;
                    cal_total_reg    <= '0;
                    cal_lowest_reg   <= ADC_TOP;
                    cal_highest_reg  <= '0;
                    cal_smoothed_reg <= '0;
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg <= 1'b1;
                        out_reg.out_channel <= ch;
                        if (c_reg.in_range)
                        begin
                            out_reg.smoothed_level <= sm_cur;
                            out_reg.press_percent  <= disp_cur;
                            out_reg.idle_level     <= idle_cur;
                            out_reg.deadband_level <= db_cur;
                        end
                        else
                        begin
                            out_reg.smoothed_level <= '0;
                            out_reg.press_percent  <= '0;
                            out_reg.idle_level     <= '0;
                            out_reg.deadband_level <= '0;
                        end
                        out_reg.cal_done      <= done_reg;
                        out_reg.load_rejected <= rej_reg;
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_item))
        else $error("result changed while stalled");
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(out_item.cal_done && out_item.load_rejected))
        else $error("done and rejected together");
    a_pct: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_item.press_percent <= 7'd100)
        else $error("percent out of range");
    a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        cal_count_reg <= CAL_SAMPLES_C)
        else $error("calibration count overrun");

endmodule

/* rtl/fsr_channel_conditioner.sv */
// Back end: load, calibration and unused codes pass from the read state to output;
// a calibration item that ends its pass adds a divide state, a measure item the percent
// and divider states (up to 20 divider steps). The back end takes one item at a time;
// the front end and a two-entry queue take up to four more items meanwhile.
// Reset (rst_n, asynchronous, active low) clears all channel state, the calibration
// pass and sets the deadband floor to 70 and the rise margin to 80.
module fsr_channel_conditioner #(
    parameter int unsigned CHANNELS    = 9,
    parameter int unsigned CAL_SAMPLES = 180,
    parameter int unsigned CAL_SKIP    = 20
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  fsrc_pkg::in_item_t  in_item,
    output logic                out_valid,
    input  logic                out_ready,
    output fsrc_pkg::out_item_t out_item,
    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [11:0]         cfg_data
);
    import fsrc_pkg::*;

    logic [11:0] db_floor_reg, rise_margin_reg;
    logic        f_valid, f_ready, q_valid, q_ready;
    cmd_t        f_cmd, q_cmd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            db_floor_reg    <= 12'd70;
            rise_margin_reg <= 12'd80;
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_DB_FLOOR)
                db_floor_reg <= cfg_data;
            else if (cfg_index == CFG_RISE_MARGIN)
                rise_margin_reg <= cfg_data;
        end
    end

    fsrc_front #(.CHANNELS(CHANNELS)) u_front (
        .clk, .rst_n, .in_valid, .in_ready, .in_item,
        .cmd_valid(f_valid), .cmd_ready(f_ready), .cmd(f_cmd)
    );

    fsrc_queue #(.WIDTH($bits(cmd_t))) u_queue (
        .clk, .rst_n,
        .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_cmd),
        .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_cmd)
    );

    fsrc_back #(
        .CHANNELS(CHANNELS), .CAL_SAMPLES(CAL_SAMPLES), .CAL_SKIP(CAL_SKIP)
    ) u_back (
        .clk, .rst_n,
        .cmd_valid(q_valid), .cmd_ready(q_ready), .cmd(q_cmd),
        .db_floor(db_floor_reg), .rise_margin(rise_margin_reg),
        .out_valid, .out_ready, .out_item
    );

endmodule
